### rtl/cfd_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the CRC-32 byte update of the COBS frame decoder.
// No dependencies; every other file of the decoder uses this package.
package cfd_pkg;

	localparam int MAX_PAYLOAD_BYTES = 4096;
	localparam int FRAME_OVERHEAD = 6;
	localparam int HEADER_BYTES = 2;
	localparam int TRAILER_BYTES = 4;
	localparam int LEN_W = 13;
	localparam int STATUS_W = 3;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
	localparam logic [31:0] CRC_ALL_ONES = 32'hFFFF_FFFF;

	localparam logic [7:0] COBS_DELIM = 8'h00;
	localparam logic [7:0] COBS_FULL_CODE = 8'hFF;

	localparam logic [STATUS_W-1:0] ST_OK = 3'd0;
	localparam logic [STATUS_W-1:0] ST_TRUNCATED = 3'd1;
	localparam logic [STATUS_W-1:0] ST_TOO_SHORT = 3'd2;
	localparam logic [STATUS_W-1:0] ST_CRC_BAD = 3'd3;
	localparam logic [STATUS_W-1:0] ST_TOO_LONG = 3'd4;

	typedef struct packed {
		logic       is_end;
		logic       truncated;
		logic [7:0] data;
	} cmd_t;

	function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
		logic [31:0] r;
		r = c ^ {24'h0, b};
		for (int k = 0; k < 8; k++) begin
			r = (r >> 1) ^ (CRC_POLY & {32{r[0]}});
		end
		return r;
	endfunction

endpackage

### rtl/cobs_crc_frame_decoder.sv
`timescale 1ns / 1ps
// COBS frame decoder with CRC-32 check; top level joining front end, queue and back end.
// Takes one link byte per cycle while in_stall is low; a byte's result, if any, passes
// through the command queue and the back end's output register. The rate is at most
// one word per cycle while out_stall is low, set by the COBS counter and byte-wide CRC.
// Asynchronous active-low reset clears the COBS state, queue, delay line and CRC.
// Depends on cfd_pkg, cfd_front, cfd_queue and cfd_back.
module cobs_crc_frame_decoder #(
	parameter int MAX_PAYLOAD_BYTES = cfd_pkg::MAX_PAYLOAD_BYTES
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [7:0]                    rx_byte,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          is_frame_end,
	output logic [7:0]                    payload_byte,
	output logic [7:0]                    frame_kind,
	output logic [7:0]                    channel_id,
	output logic [cfd_pkg::LEN_W-1:0]     payload_length,
	output logic [cfd_pkg::STATUS_W-1:0]  status
);

	logic          queue_full;
	logic          push;
	cfd_pkg::cmd_t push_cmd;
	logic          pop;
	logic          not_empty;
	cfd_pkg::cmd_t pop_cmd;

	cfd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.rx_byte    (rx_byte),
		.queue_full (queue_full),
		.push       (push),
		.cmd        (push_cmd)
	);

	cfd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (push_cmd),
		.full      (queue_full),
		.pop       (pop),
		.not_empty (not_empty),
		.pop_cmd   (pop_cmd)
	);

	cfd_back #(
		.MAX_PAYLOAD_BYTES (MAX_PAYLOAD_BYTES)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd_avail      (not_empty),
		.cmd            (pop_cmd),
		.pop            (pop),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.is_frame_end   (is_frame_end),
		.payload_byte   (payload_byte),
		.frame_kind     (frame_kind),
		.channel_id     (channel_id),
		.payload_length (payload_length),
		.status         (status)
	);

endmodule

### rtl/cfd_front.sv
`timescale 1ns / 1ps
// Front end: accepts link bytes, tracks COBS block state and issues decoded
// words and frame-end commands. Depends on cfd_pkg.
module cfd_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  logic [7:0]    rx_byte,
	input  logic          queue_full,
	output logic          push,
	output cfd_pkg::cmd_t cmd
);

	logic [7:0] bytes_left_q;
	logic       full_code_q;
	logic       open_q;
	logic       accept;
	logic       is_delim;
	logic       cmd_valid;

	assign in_stall = queue_full;
	assign accept = in_valid && !queue_full;
	assign is_delim = (rx_byte == cfd_pkg::COBS_DELIM);

	always_comb begin
		cmd_valid = 1'b0;
		cmd.is_end = 1'b0;
		cmd.truncated = 1'b0;
		cmd.data = rx_byte;
		if (is_delim) begin
			cmd_valid = open_q;
			cmd.is_end = 1'b1;
			cmd.truncated = (bytes_left_q != 8'd0);
			cmd.data = 8'd0;
		end else if (bytes_left_q == 8'd0) begin
			cmd_valid = open_q && !full_code_q;
			cmd.data = 8'd0;
		end else begin
			cmd_valid = 1'b1;
		end
	end

	assign push = accept && cmd_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_left_q <= 8'd0;
			full_code_q <= 1'b0;
			open_q <= 1'b0;
		end else if (accept) begin
			if (is_delim) begin
				bytes_left_q <= 8'd0;
				full_code_q <= 1'b0;
				open_q <= 1'b0;
			end else if (bytes_left_q == 8'd0) begin
				bytes_left_q <= rx_byte - 8'd1;
				full_code_q <= (rx_byte == cfd_pkg::COBS_FULL_CODE);
				open_q <= 1'b1;
			end else begin
				bytes_left_q <= bytes_left_q - 8'd1;
			end
		end
	end

endmodule

### rtl/cfd_queue.sv
`timescale 1ns / 1ps
// Short command queue between the front end and the back end.
// Depends on cfd_pkg.
module cfd_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  cfd_pkg::cmd_t push_cmd,
	output logic          full,
	input  logic          pop,
	output logic          not_empty,
	output cfd_pkg::cmd_t pop_cmd
);

	localparam int DEPTH = cfd_pkg::QUEUE_DEPTH;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	cfd_pkg::cmd_t mem [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic do_push;
	logic do_pop;

	assign full = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign do_push = push && !full;
	assign do_pop = pop && not_empty;
	assign pop_cmd = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### rtl/cfd_back.sv
`timescale 1ns / 1ps
// Back end: trailer delay line, CRC-32 check, frame status and output register.
// Depends on cfd_pkg.
module cfd_back #(
	parameter int MAX_PAYLOAD_BYTES = cfd_pkg::MAX_PAYLOAD_BYTES
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cmd_avail,
	input  cfd_pkg::cmd_t                 cmd,
	output logic                          pop,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          is_frame_end,
	output logic [7:0]                    payload_byte,
	output logic [7:0]                    frame_kind,
	output logic [7:0]                    channel_id,
	output logic [cfd_pkg::LEN_W-1:0]     payload_length,
	output logic [cfd_pkg::STATUS_W-1:0]  status
);

	localparam int LW = cfd_pkg::LEN_W;
	localparam int LIMIT = cfd_pkg::FRAME_OVERHEAD + MAX_PAYLOAD_BYTES;
	localparam int CNT_W = $clog2(LIMIT + 1);
	localparam int TB = cfd_pkg::TRAILER_BYTES;

	logic [CNT_W-1:0] count_q;
	logic             over_q;
	logic [7:0]       delay_q [TB];
	logic [7:0]       type_q;
	logic [7:0]       chan_q;
	logic [31:0]      crc_q;

	logic        slot_free;
	logic        at_limit;
	logic        in_header;
	logic        emits;
	logic [7:0]  crc_in;
	logic [31:0] crc_next;
	logic [31:0] got_crc;
	logic [cfd_pkg::STATUS_W-1:0] end_status;
	logic [LW-1:0] end_length;

	assign slot_free = !out_valid || !out_stall;
	assign pop = cmd_avail && slot_free;

	assign at_limit = (count_q >= CNT_W'(LIMIT));
	assign in_header = (count_q < CNT_W'(cfd_pkg::HEADER_BYTES));
	assign emits = !cmd.is_end && !at_limit && (count_q >= CNT_W'(cfd_pkg::FRAME_OVERHEAD));
	assign crc_in = in_header ? cmd.data : delay_q[0];
	assign crc_next = cfd_pkg::crc_byte(crc_q, crc_in);
	assign got_crc = {delay_q[3], delay_q[2], delay_q[1], delay_q[0]};

	always_comb begin
		end_length = '0;
		if (count_q >= CNT_W'(cfd_pkg::FRAME_OVERHEAD)) begin
			end_length = LW'(count_q - CNT_W'(cfd_pkg::FRAME_OVERHEAD));
		end
		if (over_q) begin
			end_status = cfd_pkg::ST_TOO_LONG;
			end_length = LW'(MAX_PAYLOAD_BYTES);
		end else if (cmd.truncated) begin
			end_status = cfd_pkg::ST_TRUNCATED;
		end else if (count_q < CNT_W'(cfd_pkg::FRAME_OVERHEAD)) begin
			end_status = cfd_pkg::ST_TOO_SHORT;
		end else if (got_crc != ~crc_q) begin
			end_status = cfd_pkg::ST_CRC_BAD;
		end else begin
			end_status = cfd_pkg::ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			count_q <= '0;
			over_q <= 1'b0;
			type_q <= 8'd0;
			chan_q <= 8'd0;
			crc_q <= cfd_pkg::CRC_ALL_ONES;
			for (int i = 0; i < TB; i++) begin
				delay_q[i] <= 8'd0;
			end
		end else begin
			if (slot_free) begin
				out_valid <= pop && (cmd.is_end || emits);
			end
			if (pop) begin
				if (cmd.is_end) begin
					count_q <= '0;
					over_q <= 1'b0;
					type_q <= 8'd0;
					chan_q <= 8'd0;
					crc_q <= cfd_pkg::CRC_ALL_ONES;
					for (int i = 0; i < TB; i++) begin
						delay_q[i] <= 8'd0;
					end
				end else if (at_limit) begin
					over_q <= 1'b1;
				end else begin
					count_q <= count_q + 1'b1;
					if (count_q == CNT_W'(0)) begin
						type_q <= cmd.data;
					end
					if (count_q == CNT_W'(1)) begin
						chan_q <= cmd.data;
					end
					if (in_header || emits) begin
						crc_q <= crc_next;
					end
					if (!in_header) begin
						for (int i = 0; i < TB - 1; i++) begin
							delay_q[i] <= delay_q[i+1];
						end
						delay_q[TB-1] <= cmd.data;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			frame_kind <= type_q;
			channel_id <= chan_q;
			if (cmd.is_end) begin
				is_frame_end <= 1'b1;
				payload_byte <= 8'd0;
				payload_length <= end_length;
				status <= end_status;
			end else begin
				is_frame_end <= 1'b0;
				payload_byte <= delay_q[0];
				payload_length <= '0;
				status <= cfd_pkg::ST_OK;
			end
		end
	end

endmodule

### rtl/cfd_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the COBS frame decoder and its bind to the top level.
// Depends on cfd_pkg and cobs_crc_frame_decoder.
module cfd_checker #(
	parameter int MAX_PAYLOAD_BYTES = cfd_pkg::MAX_PAYLOAD_BYTES
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic                          is_frame_end,
	input logic [7:0]                    payload_byte,
	input logic [7:0]                    frame_kind,
	input logic [7:0]                    channel_id,
	input logic [cfd_pkg::LEN_W-1:0]     payload_length,
	input logic [cfd_pkg::STATUS_W-1:0]  status
);

	localparam int LW = cfd_pkg::LEN_W;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(is_frame_end)
			&& $stable(payload_byte) && $stable(payload_length) && $stable(status)
			&& $stable(frame_kind) && $stable(channel_id))
		else $error("Stalled result word changed.");

	a_payload_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !is_frame_end |-> payload_length == '0 && status == cfd_pkg::ST_OK)
		else $error("Payload word carries frame-end fields.");

	a_end_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_frame_end |-> payload_byte == 8'd0
			&& status <= cfd_pkg::ST_TOO_LONG && payload_length <= LW'(MAX_PAYLOAD_BYTES))
		else $error("Frame-end word out of range.");

	a_too_long_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_frame_end && status == cfd_pkg::ST_TOO_LONG
			|-> payload_length == LW'(MAX_PAYLOAD_BYTES))
		else $error("Overlong frame does not report the saturated length.");

endmodule

bind cobs_crc_frame_decoder cfd_checker #(
	.MAX_PAYLOAD_BYTES (MAX_PAYLOAD_BYTES)
) u_cfd_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.is_frame_end   (is_frame_end),
	.payload_byte   (payload_byte),
	.frame_kind     (frame_kind),
	.channel_id     (channel_id),
	.payload_length (payload_length),
	.status         (status)
);
